### hdl/mcg_pkg.sv
// Package with the widths, constants and tables of the month calendar grid.
package mcg_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CELL_W  = 6;
  localparam int unsigned WD_W    = 3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Reciprocals for division by 25 (shift 17) and by 7 (shift 18).
  localparam logic [12:0] RECIP_25   = 13'd5243;
  localparam int unsigned SHIFT_25   = 17;
  localparam logic [15:0] RECIP_7    = 16'd37450;
  localparam int unsigned SHIFT_7    = 18;

  localparam logic [CELL_W-1:0] GRID_4_WEEKS = 6'd28;
  localparam logic [CELL_W-1:0] GRID_5_WEEKS = 6'd35;
  localparam logic [CELL_W-1:0] GRID_6_WEEKS = 6'd42;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [WD_W-1:0]    wd_t;

  function automatic day_t month_len(input month_t m);
    day_t len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Weekday offset of the 1st of each month, with the year counted from March.
  function automatic wd_t wd_offset(input month_t m);
    wd_t off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      default: off = 3'd4;
    endcase
    return off;
  endfunction

endpackage

### hdl/mcg_in_if.sv
// Request channel interface: year and month with valid and ready.
interface mcg_in_if;
  logic           valid;
  logic           ready;
  mcg_pkg::year_t  year;
  mcg_pkg::month_t month;

  modport source (output valid, output year, output month, input ready);
  modport sink   (input valid, input year, input month, output ready);
endinterface

### hdl/mcg_out_if.sv
// Cell channel interface: day number and last-cell flag with valid and ready.
interface mcg_out_if;
  logic          valid;
  logic          ready;
  mcg_pkg::day_t day_number;
  logic          last_cell;

  modport source (output valid, output day_number, output last_cell, input ready);
  modport sink   (input valid, input day_number, input last_cell, output ready);
endinterface

### hdl/month_calendar_grid_top.sv
// Top level of the month calendar grid generator.
//
// A request on in_ch carries a year and a month; month zero is taken as
// January and months above twelve as December. For each request the block
// sends the cells of a Sunday-first week grid on out_ch, one per transfer:
// blank cells (day 0) before the 1st, the day numbers, then blank cells up
// to the closing Saturday, with last_cell set on the final cell.
// A request goes through three register stages (clamp, divide, weekday and
// month length) and then loads the cell counter, which feeds the output
// register. The counter emits one cell per cycle while out_ch.ready is
// not held low; a request keeps it busy for the 28, 35 or 42 cells of its grid.
// Up to three further requests are taken while a grid is being sent.
// When the receiver holds out_ch.ready low, the output register holds its
// cell and the stages behind it fill and then drop in_ch.ready.
// Synchronous reset empties all stages and the output; no cell is pending.
module month_calendar_grid_top (
  input  logic              clk,
  input  logic              rst_n,
  mcg_in_if.sink            in_ch,
  mcg_out_if.source         out_ch
);

  // Stage valids and flow control.
  logic p1_v_r, p2_v_r, p3_v_r, gen_v_r, out_valid_r;
  logic out_adv, gen_emit, gen_done, gen_load, p3_free, p2_free, p1_free;

  // Stage 1 payload.
  mcg_pkg::year_t  y1_r;
  mcg_pkg::month_t m1_r, m1_nxt;

  // Stage 2 payload.
  logic [14:0]     yy_nxt, yy_r;
  logic [12:0]     q4_nxt, q4_r;
  logic [25:0]     prod_y;
  logic [7:0]      q25_r;
  logic [11:0]     c_nxt, c_r;
  logic [24:0]     prod_c;
  logic [7:0]      c25_r;
  logic            l4_r;
  mcg_pkg::month_t m2_r;

  // Stage 3 logic and payload.
  logic [5:0]      c100;
  logic [11:0]     c25x25, c100x100;
  logic            leap;
  logic [14:0]     wsum;
  logic [30:0]     prod_7;
  logic [11:0]     q7;
  logic [14:0]     rem7;
  mcg_pkg::wd_t    fw_nxt, fw3_r;
  mcg_pkg::day_t   len_nxt, len3_r;

  // Cell counter.
  mcg_pkg::cell_t  cnt_r, tot_r, fl_r, fl_nxt, tot_nxt, day_full;
  mcg_pkg::wd_t    fw_r;
  mcg_pkg::day_t   day_nxt;
  logic            last_nxt;

  // Output register.
  mcg_pkg::day_t   out_day_r;
  logic            out_last_r;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign gen_emit = gen_v_r && out_adv;
  assign gen_done = gen_emit && (cnt_r == tot_r - 6'd1);
  assign gen_load = !gen_v_r || gen_done;
  assign p3_free  = !p3_v_r || gen_load;
  assign p2_free  = !p2_v_r || p3_free;
  assign p1_free  = !p1_v_r || p2_free;

  assign in_ch.ready       = p1_free;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.day_number = out_day_r;
  assign out_ch.last_cell  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      gen_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_v_r <= in_ch.valid;
      end
      if (p2_free) begin
        p2_v_r <= p1_v_r;
      end
      if (p3_free) begin
        p3_v_r <= p2_v_r;
      end
      if (gen_load) begin
        gen_v_r <= p3_v_r;
      end
      if (out_adv) begin
        out_valid_r <= gen_v_r;
      end
    end
  end

  // Stage 1: clamp the month into range.
  always_comb begin
    if (in_ch.month == '0) begin
      m1_nxt = mcg_pkg::MONTH_JAN;
    end else if (in_ch.month > mcg_pkg::MONTH_DEC) begin
      m1_nxt = mcg_pkg::MONTH_DEC;
    end else begin
      m1_nxt = in_ch.month;
    end
  end

  // Stage 2: shifted year count and its divisions by 4 and 100, plus the
  // divisions of the plain year needed for the leap test.
  always_comb begin
    yy_nxt = 15'(y1_r) + 15'd400 - ((m1_r < mcg_pkg::MONTH_MAR) ? 15'd1 : 15'd0);
    q4_nxt = yy_nxt[14:2];
    prod_y = 26'(q4_nxt) * 26'(mcg_pkg::RECIP_25);
    c_nxt  = y1_r[13:2];
    prod_c = 25'(c_nxt) * 25'(mcg_pkg::RECIP_25);
  end

  // Stage 3: leap test, weekday of the 1st and month length.
  always_comb begin
    c100     = c25_r[7:2];
    c25x25   = 12'(c25_r) * 12'd25;
    c100x100 = 12'(c100) * 12'd100;
    leap     = l4_r && ((c25x25 != c_r) || (c100x100 == c_r));
    wsum     = yy_r + 15'(q4_r) + 15'(q25_r[7:2]) - 15'(q25_r)
               + 15'(mcg_pkg::wd_offset(m2_r)) + 15'd1;
    prod_7   = 31'(wsum) * 31'(mcg_pkg::RECIP_7);
    q7       = prod_7[mcg_pkg::SHIFT_7 +: 12];
    rem7     = wsum - 15'(q7) * 15'd7;
    fw_nxt   = rem7[2:0];
    len_nxt  = mcg_pkg::month_len(m2_r)
               + (((m2_r == mcg_pkg::MONTH_FEB) && leap) ? 5'd1 : 5'd0);
  end

  // Cell counter load values and the cell in progress.
  always_comb begin
    fl_nxt = 6'(fw3_r) + 6'(len3_r);
    if (fl_nxt <= mcg_pkg::GRID_4_WEEKS) begin
      tot_nxt = mcg_pkg::GRID_4_WEEKS;
    end else if (fl_nxt <= mcg_pkg::GRID_5_WEEKS) begin
      tot_nxt = mcg_pkg::GRID_5_WEEKS;
    end else begin
      tot_nxt = mcg_pkg::GRID_6_WEEKS;
    end
    day_full = cnt_r - 6'(fw_r) + 6'd1;
    if ((cnt_r >= 6'(fw_r)) && (cnt_r < fl_r)) begin
      day_nxt = day_full[4:0];
    end else begin
      day_nxt = '0;
    end
    last_nxt = (cnt_r == tot_r - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && p1_free) begin
      y1_r <= in_ch.year;
      m1_r <= m1_nxt;
    end
    if (p1_v_r && p2_free) begin
      yy_r  <= yy_nxt;
      q4_r  <= q4_nxt;
      q25_r <= prod_y[mcg_pkg::SHIFT_25 +: 8];
      c_r   <= c_nxt;
      c25_r <= prod_c[mcg_pkg::SHIFT_25 +: 8];
      l4_r  <= (y1_r[1:0] == 2'd0);
      m2_r  <= m1_r;
    end
    if (p2_v_r && p3_free) begin
      fw3_r  <= fw_nxt;
      len3_r <= len_nxt;
    end
    if (gen_load && p3_v_r) begin
      cnt_r <= '0;
      fw_r  <= fw3_r;
      fl_r  <= fl_nxt;
      tot_r <= tot_nxt;
    end else if (gen_emit) begin
      cnt_r <= cnt_r + 6'd1;
    end
    if (gen_emit) begin
      out_day_r  <= day_nxt;
      out_last_r <= last_nxt;
    end
  end

endmodule
